// ===== src/cts_pkg.sv =====
// cts_pkg: shared types, constants and byte-folding functions for the
// command text sanitizer. No dependencies.
`timescale 1ns / 1ps

package cts_pkg;

    localparam int BUDGET_W  = 13;
    localparam int MAX_RES   = 5;   // most results one word can cause
    localparam int RES_DEPTH = 8;   // result queue entries
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 13'd1024;

    localparam logic [7:0] SEP_BYTE  = 8'h20;
    localparam logic [7:0] DEL_BYTE  = 8'h7f;
    localparam logic [7:0] LEAD2_MSK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL = 8'hC0;
    localparam logic [7:0] LEAD3_MSK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL = 8'hE0;
    localparam logic [7:0] LEAD4_MSK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL = 8'hF0;
    localparam logic [7:0] CONT_MSK  = 8'hC0;
    localparam logic [7:0] CONT_VAL  = 8'h80;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } cts_res_t;

    // results of one word, in order, towards the result queue
    typedef struct packed {
        cts_res_t [MAX_RES-1:0] res;
        logic [2:0]             n;
    } cts_res_wr_t;

    // per-string folding state
    typedef struct packed {
        logic [2:0][7:0]     held;
        logic [1:0]          cnt;
        logic [1:0]          skip;
        logic                sep;
        logic [BUDGET_W-1:0] flen;
    } cts_hold_t;

    typedef struct packed {
        cts_hold_t  st;
        logic       emit;
        logic [7:0] ebyte;
    } cts_push_t;

    function automatic logic [2:0] cts_want(logic [7:0] b);
        if ((b & LEAD2_MSK) == LEAD2_VAL) return 3'd2;
        if ((b & LEAD3_MSK) == LEAD3_VAL) return 3'd3;
        if ((b & LEAD4_MSK) == LEAD4_VAL) return 3'd4;
        return 3'd1;
    endfunction

    function automatic logic cts_cont(logic [7:0] b);
        return (b & CONT_MSK) == CONT_VAL;
    endfunction

    // append one folded byte; the oldest held byte leaves once three are held
    function automatic cts_push_t cts_push(cts_hold_t s, logic [7:0] b);
        cts_push_t  r;
        logic [2:0] want;
        logic       ok;
        r       = '0;
        r.st    = s;
        r.ebyte = s.held[0];
        want    = cts_want(s.held[0]);
        case (want)
            3'd2:    ok = cts_cont(s.held[1]);
            3'd3:    ok = cts_cont(s.held[1]) & cts_cont(s.held[2]);
            3'd4:    ok = cts_cont(s.held[1]) & cts_cont(s.held[2]) & cts_cont(b);
            default: ok = 1'b0;
        endcase
        if (s.cnt == 2'd3) begin
            if (s.skip != 2'd0) begin
                r.st.skip = s.skip - 2'd1;
            end else if (ok) begin
                r.st.skip = 2'(want - 3'd1);
            end
            r.emit    = 1'b1;
            r.st.held = {b, s.held[2], s.held[1]};
        end else begin
            r.st.held[s.cnt] = b;
            r.st.cnt         = s.cnt + 2'd1;
        end
        r.st.flen = s.flen + 13'd1;
        return r;
    endfunction

    // number of held bytes that survive the end-of-string cut
    function automatic logic [1:0] cts_keep(cts_hold_t s);
        logic [1:0] keep;
        logic [1:0] skip;
        logic       done;
        logic       ok;
        logic [2:0] want;
        keep = s.cnt;
        skip = s.skip;
        done = 1'b0;
        for (int j = 0; j < 3; j++) begin
            ok   = 1'b1;
            want = cts_want(s.held[j]);
            for (int k = 1; k < 3; k++) begin
                if (k > j && k < j + int'(want) && !cts_cont(s.held[k])) begin
                    ok = 1'b0;
                end
            end
            if (!done && j < int'(s.cnt)) begin
                if (skip != 2'd0) begin
                    skip = skip - 2'd1;
                end else if (want != 3'd1) begin
                    if (j + int'(want) > int'(s.cnt)) begin
                        keep = 2'(j);
                        done = 1'b1;
                    end else if (ok) begin
                        skip = 2'(want - 3'd1);
                    end
                end
            end
        end
        return keep;
    endfunction

endpackage

// ===== src/cts_fold.sv =====
// cts_fold: input register, budget register and the single-pass fold/flush
// logic. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_fold (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_budget_we,
    input  logic [cts_pkg::BUDGET_W-1:0] byte_budget,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   raw_byte,
    input  logic                         end_of_string,
    input  logic                         space_ok,
    output cts_pkg::cts_res_wr_t         res_wr
);

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   byte_reg;
    logic                         eos_reg;
    logic [cts_pkg::BUDGET_W-1:0] budget_reg;
    cts_pkg::cts_hold_t           state_reg, state_next;

    logic                advance;
    logic                is_sep;
    cts_pkg::cts_push_t  p1, p2;
    logic [1:0]          keep;
    logic [2:0]          n;

    assign advance  = in_valid_reg & space_ok;
    assign in_ready = ~in_valid_reg | space_ok;
    assign is_sep   = (byte_reg <= cts_pkg::SEP_BYTE) || (byte_reg == cts_pkg::DEL_BYTE);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid & in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_wr     = '0;
        p1         = '0;
        p2         = '0;
        keep       = 2'd0;
        n          = 3'd0;
        if (advance)
        begin
            if (state_reg.flen < budget_reg)
            begin
                if (is_sep)
                begin
                    state_next.sep = (state_reg.flen != '0);
                end
                else if (state_reg.sep)
                begin
                    if ({1'b0, state_reg.flen} + 14'd2 <= {1'b0, budget_reg})
                    begin
                        p1 = cts_pkg::cts_push(state_reg, cts_pkg::SEP_BYTE);
                        if (p1.emit)
                        begin
                            res_wr.res[n] = {p1.ebyte, 1'b0, 1'b0};
                            n = n + 3'd1;
                        end
                        p2 = cts_pkg::cts_push(p1.st, byte_reg);
                        if (p2.emit)
                        begin
                            res_wr.res[n] = {p2.ebyte, 1'b0, 1'b0};
                            n = n + 3'd1;
                        end
                        state_next     = p2.st;
                        state_next.sep = 1'b0;
                    end
                end
                else
                begin
                    p1 = cts_pkg::cts_push(state_reg, byte_reg);
                    if (p1.emit)
                    begin
                        res_wr.res[n] = {p1.ebyte, 1'b0, 1'b0};
                        n = n + 3'd1;
                    end
                    state_next = p1.st;
                end
            end
            if (eos_reg)
            begin
                keep = cts_pkg::cts_keep(state_next);
                if (keep == 2'd0)
                begin
                    res_wr.res[n] = {8'd0, 1'b1, 1'b1};
                    n = n + 3'd1;
                end
                else
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        if (j < int'(keep))
                        begin
                            res_wr.res[n] = {state_next.held[j], (j + 1 == int'(keep)), 1'b0};
                            n = n + 3'd1;
                        end
                    end
                end
                state_next = '0;
            end
        end
        res_wr.n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            budget_reg   <= cts_pkg::BUDGET_RESET;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            if (byte_budget_we)
            begin
                budget_reg <= byte_budget;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            byte_reg <= raw_byte;
            eos_reg  <= end_of_string;
        end
    end

endmodule

// ===== src/cts_res_fifo.sv =====
// cts_res_fifo: result queue, takes up to MAX_RES results a cycle and hands
// out one. Depends on cts_pkg.
`timescale 1ns / 1ps

module cts_res_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cts_pkg::cts_res_wr_t res_wr,
    output logic                 space_ok,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cts_pkg::cts_res_t    head
);

    cts_pkg::cts_res_t                 mem [cts_pkg::RES_DEPTH];
    logic [cts_pkg::RES_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [cts_pkg::RES_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [cts_pkg::RES_CNT_W-1:0]     count_reg, count_next;
    logic                              pop;

    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign pop       = out_valid & out_ready;
    // room for a whole word's results before the stage fires
    assign space_ok  = (count_reg <= cts_pkg::RES_CNT_W'(cts_pkg::RES_DEPTH - cts_pkg::MAX_RES));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + cts_pkg::RES_PTR_W'(res_wr.n);
        rd_ptr_next = rd_ptr_reg + cts_pkg::RES_PTR_W'(pop);
        count_next  = count_reg + cts_pkg::RES_CNT_W'(res_wr.n)
                      - cts_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < cts_pkg::MAX_RES; k++)
        begin
            if (k < int'(res_wr.n))
            begin
                mem[wr_ptr_reg + cts_pkg::RES_PTR_W'(k)] <= res_wr.res[k];
            end
        end
    end

endmodule

// ===== src/command_text_sanitizer.sv =====
// command_text_sanitizer: top level, joins the fold stage and the result
// queue. Depends on cts_pkg, cts_fold and cts_res_fifo.
//
// Usage
//   Input channel (in_valid/in_ready): one raw command byte a word, with
//   end_of_string high on the final byte of each string.
//   Output channel (out_valid/out_ready): one sanitized byte a word, with
//   last_of_string on the final word of a string; a string that folds to
//   nothing gives one word with string_empty high and clean_byte zero.
//   byte_budget_we/byte_budget write the output budget; write only when idle.
// Path: a word accepted sits in the input register, is folded into the result
//   queue once the queue has room, and shows on the output from the queue head.
// Throughput: one word a cycle while each word yields at most one result;
//   an end-of-string word may yield up to five, drained one a cycle from the
//   eight-entry result queue. The fold stage fires only when the queue has
//   room for five, so it holds while more than three results wait, and
//   in_ready drops once a word is also waiting in the input register.
// Stall: a stalled receiver fills the queue, then the input register, then
//   in_ready goes low; nothing is lost.
// Reset: clears the queue, the input register and all string state, and sets
//   the budget to 1024 bytes.
`timescale 1ns / 1ps

module command_text_sanitizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_budget_we,
    input  logic [cts_pkg::BUDGET_W-1:0] byte_budget,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   raw_byte,
    input  logic                         end_of_string,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   clean_byte,
    output logic                         last_of_string,
    output logic                         string_empty
);

    cts_pkg::cts_res_wr_t res_wr;
    cts_pkg::cts_res_t    head;
    logic                 space_ok;

    cts_fold u_fold (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_budget_we (byte_budget_we),
        .byte_budget    (byte_budget),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .raw_byte       (raw_byte),
        .end_of_string  (end_of_string),
        .space_ok       (space_ok),
        .res_wr         (res_wr)
    );

    cts_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_wr    (res_wr),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign clean_byte     = head.data;
    assign last_of_string = head.last;
    assign string_empty   = head.empty;

    // fold stage only writes when the queue had room
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (res_wr.n != 3'd0) |-> space_ok)
        else $error("results written without queue room");

    // never more results than one word can cause
    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_wr.n <= 3'(cts_pkg::MAX_RES))
        else $error("too many results for one word");

    // an empty-string result closes the string and carries no byte
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_empty) |-> (last_of_string && clean_byte == 8'd0))
        else $error("empty result without last mark or with data");

endmodule
